@@ rtl/wcm_pkg.sv @@
// Shared types and constants for the concatenated-word window matcher.
package wcm_pkg;

  localparam int MAX_WORDS_DEF    = 16;
  localparam int MAX_WORD_LEN_DEF = 16;
  localparam int POS_BITS_DEF     = 32;
  localparam int CFG_BITS         = 5;

  localparam logic REG_WORD_LEN   = 1'b0;
  localparam logic REG_WORD_COUNT = 1'b1;

  typedef enum logic [1:0] {
    MODE_DICT = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_NEW  = 2'd2,
    MODE_CLR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUP,
    ST_CMP,
    ST_LOOK,
    ST_CHECK,
    ST_EVRD,
    ST_EVAP
  } state_t;

  typedef struct packed {
    logic clr_all_seen;
    logic clr_ph_seen;
    logic inc_seen;
    logic dec_seen;
    logic clr_req;
    logic inc_req;
    logic load;
  } cell_op_t;

endpackage

@@ rtl/wcm_cell.sv @@
// One dictionary slot: stored word, required count and per-phase seen counts.
module wcm_cell #(
  parameter int MAX_WORDS    = wcm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_LEN = wcm_pkg::MAX_WORD_LEN_DEF,
  parameter int K            = 0,
  localparam int IW = $clog2(MAX_WORDS + 1),
  localparam int PW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1,
  localparam int LW = $clog2(MAX_WORD_LEN + 1),
  localparam int CW = $clog2(MAX_WORDS + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wcm_pkg::cell_op_t op,
  input  logic [IW-1:0]    op_id,
  input  logic [PW-1:0]    ph,
  input  logic [IW-1:0]    fill,
  input  logic [LW-1:0]    wl,
  input  logic [7:0]       load_data [MAX_WORD_LEN],
  input  logic [7:0]       cmp_data  [MAX_WORD_LEN],
  input  logic             claim_in,
  output logic             claim_out,
  output logic             hit,
  input  logic [IW-1:0]    sel_id,
  input  logic [CW-1:0]    sel_seen_in,
  input  logic [CW-1:0]    sel_req_in,
  output logic [CW-1:0]    sel_seen_out,
  output logic [CW-1:0]    sel_req_out
);

  logic [7:0]    word_r [MAX_WORD_LEN];
  logic [CW-1:0] req_r;
  logic [CW-1:0] seen_r [MAX_WORD_LEN];
  logic          match;
  logic          valid;
  logic          mine;

  always_comb begin
    match = 1'b1;
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      if ((LW'(j) < wl) && (word_r[j] != cmp_data[j])) begin
        match = 1'b0;
      end
    end
  end

  assign valid        = IW'(K) < fill;
  assign mine         = op_id == IW'(K);
  assign hit          = valid && match && !claim_in;
  assign claim_out    = claim_in || (valid && match);
  assign sel_seen_out = (sel_id == IW'(K)) ? seen_r[ph] : sel_seen_in;
  assign sel_req_out  = (sel_id == IW'(K)) ? req_r : sel_req_in;

  always_ff @(posedge clk) begin
    if (op.load && mine) begin
      word_r <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
        seen_r[j] <= '0;
      end
    end else begin
      priority if (op.clr_req) begin
        req_r <= '0;
      end else if (op.inc_req && mine) begin
        req_r <= req_r + CW'(1);
      end else if (op.load && mine) begin
        req_r <= CW'(1);
      end
      priority if (op.clr_all_seen) begin
        for (int j = 0; j < MAX_WORD_LEN; j++) begin
          seen_r[j] <= '0;
        end
      end else if (op.clr_ph_seen) begin
        seen_r[ph] <= '0;
      end else if (op.inc_seen && mine) begin
        seen_r[ph] <= seen_r[ph] + CW'(1);
      end else if (op.dec_seen && mine && (seen_r[ph] != '0)) begin
        seen_r[ph] <= seen_r[ph] - CW'(1);
      end
    end
  end

endmodule

@@ rtl/word_concat_window_matcher_core.sv @@
// Top level: control sequencer, phase windows, word-id ring and the cell chain.
// Dictionary byte: a byte that completes a word also runs a duplicate check in the chain.
// Text byte: a byte that ends a word is looked up; a word not in the dictionary resets its
// phase window, else surplus words are evicted and, on a match, the match is emitted and evicted.
// Items are taken one at a time; a held result stalls only the next match.
// Reset is synchronous, active low; all state is ready on the first cycle after it.
module word_concat_window_matcher_core #(
  parameter int MAX_WORDS    = wcm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_LEN = wcm_pkg::MAX_WORD_LEN_DEF,
  parameter int POS_BITS     = wcm_pkg::POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_match_start,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW  = $clog2(MAX_WORDS + 1);
  localparam int PW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int LW  = $clog2(MAX_WORD_LEN + 1);
  localparam int CW  = $clog2(MAX_WORDS + 2);
  localparam int RL  = $clog2(MAX_WORDS * MAX_WORD_LEN) > 0 ?
                       $clog2(MAX_WORDS * MAX_WORD_LEN) : 1;
  localparam int RA  = RL < POS_BITS ? RL : POS_BITS;
  localparam int RD  = 1 << RA;

  logic [wcm_pkg::CFG_BITS-1:0] word_len_r, word_count_r;
  wcm_pkg::state_t state_r, state_nxt;
  logic [POS_BITS-1:0] pos_r;
  logic [POS_BITS-1:0] s_r;
  logic [POS_BITS-1:0] left_r [MAX_WORD_LEN];
  logic [CW-1:0]       tot_r  [MAX_WORD_LEN];
  logic [7:0]          win_r  [MAX_WORD_LEN];
  logic [7:0]          stg_r  [MAX_WORD_LEN];
  logic [LW-1:0]       pc_r;
  logic [IW-1:0]       fill_r;
  logic [CW-1:0]       words_r;
  logic [PW-1:0]       ph_r, wph_r;
  logic [IW-1:0]       id_r;
  logic [IW-1:0]       rd_r;
  logic                after_r;
  logic                out_valid_r;
  logic [31:0]         out_data_r;
  logic [IW-1:0]       ring [RD];

  logic [LW-1:0] wl;
  logic [CW-1:0] wc;
  logic          accept, cfg_wr, sat, word_end, dict_ign, dict_done;
  logic          clr_text, clr_dict, out_free, ev_cond, dup_hit, emit;
  logic [IW-1:0] enc_id;
  wcm_pkg::mode_t mode;
  wcm_pkg::cell_op_t op;
  logic [IW-1:0] op_id, sel_id;
  logic [7:0]    cmp_data [MAX_WORD_LEN];
  logic [MAX_WORDS-1:0] hit_w;
  logic          claim [MAX_WORDS+1];
  logic [CW-1:0] seen_ch [MAX_WORDS+1];
  logic [CW-1:0] req_ch  [MAX_WORDS+1];
  logic [CW-1:0] sel_seen, sel_req;

  assign wl = (word_len_r == '0) ? LW'(1) :
              ((int'(word_len_r) > MAX_WORD_LEN) ? LW'(MAX_WORD_LEN) : LW'(word_len_r));
  assign wc = (word_count_r == '0) ? CW'(1) :
              ((int'(word_count_r) > MAX_WORDS) ? CW'(MAX_WORDS) : CW'(word_count_r));

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == wcm_pkg::REG_WORD_COUNT) ? 32'(word_count_r)
                                                           : 32'(word_len_r);
  assign cfg_wr    = psel && penable && pwrite;
  assign in_stall  = state_r != wcm_pkg::ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign mode      = wcm_pkg::mode_t'(in_mode);
  assign sat       = &pos_r;
  assign word_end  = (pos_r + POS_BITS'(1)) >= POS_BITS'(wl);
  assign dict_ign  = (words_r >= wc) || (int'(fill_r) >= MAX_WORDS);
  assign dict_done = (pc_r + LW'(1)) == wl;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_match_start = out_data_r;

  assign clr_dict = cfg_wr || (accept && mode == wcm_pkg::MODE_CLR);
  assign clr_text = clr_dict ||
                    (accept && (mode == wcm_pkg::MODE_DICT || mode == wcm_pkg::MODE_NEW));

  // cell chain
  assign claim[0]   = 1'b0;
  assign seen_ch[0] = '0;
  assign req_ch[0]  = '0;
  assign sel_seen   = seen_ch[MAX_WORDS];
  assign sel_req    = req_ch[MAX_WORDS];
  assign cmp_data   = (state_r == wcm_pkg::ST_DUP) ? stg_r : win_r;

  for (genvar k = 0; k < MAX_WORDS; k++) begin : g_cell
    wcm_cell #(
      .MAX_WORDS   (MAX_WORDS),
      .MAX_WORD_LEN(MAX_WORD_LEN),
      .K           (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .op_id       (op_id),
      .ph          (wph_r),
      .fill        (fill_r),
      .wl          (wl),
      .load_data   (stg_r),
      .cmp_data    (cmp_data),
      .claim_in    (claim[k]),
      .claim_out   (claim[k+1]),
      .hit         (hit_w[k]),
      .sel_id      (sel_id),
      .sel_seen_in (seen_ch[k]),
      .sel_req_in  (req_ch[k]),
      .sel_seen_out(seen_ch[k+1]),
      .sel_req_out (req_ch[k+1])
    );
  end

  always_comb begin
    enc_id = IW'(MAX_WORDS);
    for (int k = 0; k < MAX_WORDS; k++) begin
      if (hit_w[k]) begin
        enc_id = IW'(k);
      end
    end
  end

  assign dup_hit = |hit_w;
  assign sel_id  = id_r;
  assign ev_cond = (tot_r[wph_r] != '0) && (sel_seen > sel_req);
  assign emit    = (state_r == wcm_pkg::ST_CHECK) && !ev_cond && (tot_r[wph_r] >= wc) &&
                   out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wcm_pkg::ST_IDLE: begin
        if (accept && !cfg_wr) begin
          if (mode == wcm_pkg::MODE_TEXT && !sat && word_end) begin
            state_nxt = wcm_pkg::ST_CMP;
          end else if (mode == wcm_pkg::MODE_DICT && !dict_ign && dict_done) begin
            state_nxt = wcm_pkg::ST_DUP;
          end
        end
      end
      wcm_pkg::ST_DUP:  state_nxt = wcm_pkg::ST_IDLE;
      wcm_pkg::ST_CMP:  state_nxt = wcm_pkg::ST_LOOK;
      wcm_pkg::ST_LOOK: begin
        state_nxt = (int'(id_r) >= MAX_WORDS) ? wcm_pkg::ST_IDLE : wcm_pkg::ST_CHECK;
      end
      wcm_pkg::ST_CHECK: begin
        priority if (ev_cond) begin
          state_nxt = wcm_pkg::ST_EVRD;
        end else if (tot_r[wph_r] >= wc) begin
          state_nxt = out_free ? wcm_pkg::ST_EVRD : wcm_pkg::ST_CHECK;
        end else begin
          state_nxt = wcm_pkg::ST_IDLE;
        end
      end
      wcm_pkg::ST_EVRD: state_nxt = wcm_pkg::ST_EVAP;
      wcm_pkg::ST_EVAP: state_nxt = after_r ? wcm_pkg::ST_IDLE : wcm_pkg::ST_CHECK;
      default:          state_nxt = wcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op = '0;
    op_id = id_r;
    op.clr_all_seen = clr_text;
    op.clr_req      = clr_dict;
    unique case (state_r)
      wcm_pkg::ST_DUP: begin
        op.inc_req = dup_hit;
        op.load    = !dup_hit;
        op_id      = dup_hit ? enc_id : fill_r;
      end
      wcm_pkg::ST_LOOK: begin
        op.clr_ph_seen = int'(id_r) >= MAX_WORDS;
        op.inc_seen    = int'(id_r) < MAX_WORDS;
      end
      wcm_pkg::ST_EVAP: begin
        op.dec_seen = int'(rd_r) < MAX_WORDS;
        op_id       = rd_r;
      end
      default: begin
        op_id = id_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == wcm_pkg::ST_LOOK) begin
      ring[s_r[RA-1:0]] <= id_r;
    end
    rd_r <= ring[left_r[wph_r][RA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && mode == wcm_pkg::MODE_TEXT && !sat) begin
      win_r[0] <= in_data_byte;
      for (int j = 1; j < MAX_WORD_LEN; j++) begin
        win_r[j] <= win_r[j-1];
      end
    end
    if (accept && mode == wcm_pkg::MODE_DICT && !dict_ign) begin
      stg_r[0] <= in_data_byte;
      for (int j = 1; j < MAX_WORD_LEN; j++) begin
        stg_r[j] <= stg_r[j-1];
      end
    end
    if (accept && word_end) begin
      s_r <= pos_r + POS_BITS'(1) - POS_BITS'(wl);
    end
    if (state_r == wcm_pkg::ST_CMP) begin
      id_r <= enc_id;
    end
    if (emit) begin
      out_data_r <= 32'(left_r[wph_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wcm_pkg::ST_IDLE;
      word_len_r   <= wcm_pkg::CFG_BITS'(1);
      word_count_r <= wcm_pkg::CFG_BITS'(1);
      pos_r        <= '0;
      pc_r         <= '0;
      fill_r       <= '0;
      words_r      <= '0;
      ph_r         <= '0;
      wph_r        <= '0;
      after_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
        left_r[j] <= '0;
        tot_r[j]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == wcm_pkg::REG_WORD_LEN) begin
          word_len_r <= pwdata[wcm_pkg::CFG_BITS-1:0];
        end else begin
          word_count_r <= pwdata[wcm_pkg::CFG_BITS-1:0];
        end
      end
      if (clr_dict) begin
        fill_r  <= '0;
        words_r <= '0;
        pc_r    <= '0;
      end
      if (clr_text) begin
        pos_r <= '0;
        ph_r  <= '0;
        for (int j = 0; j < MAX_WORD_LEN; j++) begin
          left_r[j] <= '0;
          tot_r[j]  <= '0;
        end
      end
      if (accept && !cfg_wr) begin
        if (mode == wcm_pkg::MODE_DICT && !dict_ign && !dict_done) begin
          pc_r <= pc_r + LW'(1);
        end
        if (mode == wcm_pkg::MODE_TEXT && !sat) begin
          pos_r <= pos_r + POS_BITS'(1);
          if (word_end) begin
            wph_r <= ph_r;
            ph_r  <= (LW'(ph_r) + LW'(1) == wl) ? '0 : ph_r + PW'(1);
          end
        end
      end
      unique case (state_r)
        wcm_pkg::ST_DUP: begin
          pc_r    <= '0;
          words_r <= words_r + CW'(1);
          if (!dup_hit) begin
            fill_r <= fill_r + IW'(1);
          end
        end
        wcm_pkg::ST_LOOK: begin
          if (int'(id_r) >= MAX_WORDS) begin
            tot_r[wph_r]  <= '0;
            left_r[wph_r] <= s_r + POS_BITS'(wl);
          end else begin
            if (tot_r[wph_r] == '0) begin
              left_r[wph_r] <= s_r;
            end
            tot_r[wph_r] <= tot_r[wph_r] + CW'(1);
          end
        end
        wcm_pkg::ST_CHECK: begin
          if (ev_cond) begin
            after_r <= 1'b0;
          end else if (emit) begin
            after_r <= 1'b1;
          end
        end
        wcm_pkg::ST_EVAP: begin
          left_r[wph_r] <= left_r[wph_r] + POS_BITS'(wl);
          if (tot_r[wph_r] != '0) begin
            tot_r[wph_r] <= tot_r[wph_r] - CW'(1);
          end
        end
        default: begin
          after_r <= after_r;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_words_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    words_r <= wc) else $error("loaded word total exceeds word count");
  a_fill_le_words: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= words_r) else $error("distinct slots exceed loaded words");
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wcm_pkg::ST_CMP || state_r == wcm_pkg::ST_DUP) |-> $onehot0(hit_w))
    else $error("more than one cell claimed the word");
`endif

endmodule

@@ tb/word_concat_window_matcher_core_tb.sv @@
// Self-checking testbench for the concatenated-word window matcher core.
module word_concat_window_matcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = 16;
  localparam int NL = 16;
  localparam int RING = NW * NL;
  localparam int NO_ID = NW;
  localparam logic [31:0] POS_TOP = 32'hFFFF_FFFF;
  localparam int LIMIT = 3_000_000;
  localparam int DRAIN = 60;
  localparam logic [2:0] ADDR_LEN = 3'd0;
  localparam logic [2:0] ADDR_CNT = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [7:0] in_data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_match_start;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  word_concat_window_matcher_core dut (.*);

  // predictor state
  logic [7:0] dict_chars [RING];
  logic [4:0] req_cnt [NW];
  int unsigned dict_fill;
  logic [7:0] recent [NL];
  int unsigned id_ring [RING];
  logic [32:0] left_edge [NL];
  int unsigned word_total [NL];
  int unsigned seen [NL][NW];
  logic [32:0] text_pos;
  int unsigned cfg_len, cfg_cnt;

  logic [31:0] match_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_rx = 1'b0;
  bit rx_quiet = 1'b0;

  function automatic int unsigned eff_len();
    return cfg_len < 1 ? 1 : (cfg_len > NL ? NL : cfg_len);
  endfunction

  function automatic int unsigned eff_cnt();
    return cfg_cnt < 1 ? 1 : (cfg_cnt > NW ? NW : cfg_cnt);
  endfunction

  task automatic clear_text();
    text_pos = '0;
    for (int p = 0; p < NL; p++) begin
      left_edge[p] = '0;
      word_total[p] = 0;
      for (int k = 0; k < NW; k++) seen[p][k] = 0;
    end
  endtask

  task automatic clear_dict();
    dict_fill = 0;
    for (int k = 0; k < NW; k++) req_cnt[k] = '0;
    clear_text();
  endtask

  task automatic load_dict_byte(input logic [7:0] b);
    int unsigned wl, sum, slot;
    bit same;
    wl = eff_len();
    sum = 0;
    clear_text();
    for (int k = 0; k < NW; k++) sum += req_cnt[k];
    if (sum >= eff_cnt() || dict_fill >= NW * wl) return;
    dict_chars[dict_fill % RING] = b;
    dict_fill++;
    if (dict_fill % wl != 0) return;
    slot = dict_fill / wl - 1;
    for (int k = 0; k < slot; k++) begin
      same = 1'b1;
      for (int i = 0; i < wl; i++)
        if (dict_chars[k*wl+i] != dict_chars[slot*wl+i]) same = 1'b0;
      if (same) begin
        req_cnt[k]++;
        dict_fill -= wl;
        return;
      end
    end
    req_cnt[slot] = 1;
  endtask

  task automatic evict_left(input int unsigned ph, input int unsigned wl);
    int unsigned lid;
    lid = id_ring[left_edge[ph] % RING];
    if (lid < NW && seen[ph][lid] > 0) seen[ph][lid]--;
    left_edge[ph] += wl;
    if (word_total[ph] > 0) word_total[ph]--;
  endtask

  task automatic scan_text_byte(input logic [7:0] b);
    int unsigned wl, ph, nd, id;
    logic [32:0] p, s;
    bit same;
    wl = eff_len();
    id = NO_ID;
    if (text_pos >= {1'b0, POS_TOP}) return;
    p = text_pos;
    recent[p % NL] = b;
    text_pos = p + 1;
    if (p + 1 < wl) return;
    s = p + 1 - wl;
    ph = 32'(s % wl);
    nd = dict_fill / wl;
    for (int k = 0; k < nd && id == NO_ID; k++) begin
      same = 1'b1;
      for (int i = 0; i < wl; i++)
        if (dict_chars[k*wl+i] != recent[(s+i) % NL]) same = 1'b0;
      if (same) id = k;
    end
    id_ring[s % RING] = id;
    if (id == NO_ID) begin
      for (int k = 0; k < NW; k++) seen[ph][k] = 0;
      word_total[ph] = 0;
      left_edge[ph] = p + 1;
      return;
    end
    if (word_total[ph] == 0) left_edge[ph] = s;
    seen[ph][id]++;
    word_total[ph]++;
    while (word_total[ph] > 0 && seen[ph][id] > req_cnt[id]) evict_left(ph, wl);
    if (word_total[ph] >= eff_cnt()) begin
      match_q = {match_q, left_edge[ph][31:0]};
      evict_left(ph, wl);
    end
  endtask

  task automatic predict(input logic [1:0] m, input logic [7:0] b);
    case (wcm_pkg::mode_t'(m))
      wcm_pkg::MODE_DICT: load_dict_byte(b);
      wcm_pkg::MODE_TEXT: scan_text_byte(b);
      wcm_pkg::MODE_NEW:  clear_text();
      default:            clear_dict();
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  task automatic cfg_write(input logic [2:0] a, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_LEN) cfg_len = v[4:0];
    else if (a == ADDR_CNT) cfg_cnt = v[4:0];
    if (a == ADDR_LEN || a == ADDR_CNT) clear_dict();
  endtask

  task automatic wait_idle();
    while (match_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_word(input logic [1:0] m, input logic [7:0] b);
    in_valid <= 1'b1; in_mode <= m; in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(m, b);
  endtask

  // bursts with gaps; valid stays high across back-to-back words
  task automatic send(input logic [1:0] m, input logic [7:0] b);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    send_word(m, b);
  endtask

  task automatic pause_tx();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_rx) out_stall <= hold_rx;
    else if (rx_quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (match_q.size() == 0) report("unexpected", out_match_start, '0);
      else begin
        if (out_match_start !== match_q[0]) report("match_start", out_match_start, match_q[0]);
        void'(match_q.pop_front());
      end
    end
  end

  typedef struct {
    logic [1:0] m;
    logic [7:0] b;
    bit chk;
    logic [31:0] want;
  } row_t;

  // word_len 2, word_count 2: dict "ab","ab" plus text; match at 0 in "abab"
  row_t dir_tab[] = '{
    '{wcm_pkg::MODE_DICT, 8'h61, 0, 0}, '{wcm_pkg::MODE_DICT, 8'h62, 0, 0},
    '{wcm_pkg::MODE_DICT, 8'h61, 0, 0}, '{wcm_pkg::MODE_DICT, 8'h62, 0, 0},
    '{wcm_pkg::MODE_DICT, 8'hFF, 0, 0},
    '{wcm_pkg::MODE_TEXT, 8'h61, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'h62, 0, 0},
    '{wcm_pkg::MODE_TEXT, 8'h61, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'h62, 1, 32'd0},
    '{wcm_pkg::MODE_TEXT, 8'h61, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'h62, 0, 0},
    '{wcm_pkg::MODE_TEXT, 8'h00, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'hFF, 0, 0},
    '{wcm_pkg::MODE_NEW,  8'hFF, 0, 0},
    '{wcm_pkg::MODE_TEXT, 8'h61, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'h62, 0, 0},
    '{wcm_pkg::MODE_TEXT, 8'h61, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'h62, 1, 32'd0},
    '{wcm_pkg::MODE_CLR,  8'h00, 0, 0},
    '{wcm_pkg::MODE_TEXT, 8'h61, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'h62, 0, 0},
    '{wcm_pkg::MODE_DICT, 8'h61, 0, 0},
    '{wcm_pkg::MODE_TEXT, 8'h61, 0, 0}, '{wcm_pkg::MODE_TEXT, 8'h62, 0, 0}
  };

  int unsigned len_set[6] = '{1, 16, 2, 3, 0, 31};
  int unsigned cnt_set[6] = '{1, 16, 3, 2, 0, 31};

  initial begin
    int unsigned wl, wc, nloaded, nitems, alpha;
    logic [7:0] words [NW][NL];
    int pick;
    cfg_len = 1; cfg_cnt = 1;
    clear_dict();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(ADDR_LEN, 32'd2);
    cfg_write(ADDR_CNT, 32'd2);
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].m, dir_tab[i].b);
      if (dir_tab[i].chk && (match_q.size() == 0 || match_q[$] !== dir_tab[i].want))
        report("table", match_q.size() ? match_q[$] : '0, dir_tab[i].want);
    end
    pause_tx();
    wait_idle();
    cfg_write(ADDR_CNT, 32'h1F);

    nitems = dir_tab.size();
    for (int ph = 0; nitems < 1950; ph++) begin
      pause_tx();
      wait_idle();
      if (ph < 6) begin wl = len_set[ph]; wc = cnt_set[ph]; end
      else begin wl = $urandom_range(1, 4); wc = $urandom_range(1, 5); end
      if (ph % 3 == 0) wl = {$urandom} & 5'h1F;
      if (ph > 6 && wl > 6) wl = $urandom_range(1, 4);
      cfg_write(ADDR_LEN, wl);
      cfg_write(ADDR_CNT, wc);
      wl = eff_len(); wc = eff_cnt();
      alpha = $urandom_range(0, 1) ? 2 : 256;
      nloaded = wc;
      for (int k = 0; k < nloaded; k++) begin
        for (int i = 0; i < wl; i++) begin
          words[k][i] = (alpha == 2) ? 8'(8'h41 + $urandom_range(0, 1)) : 8'($urandom);
          if (k > 0 && $urandom_range(0, 3) == 0) words[k][i] = words[0][i];
          send(wcm_pkg::MODE_DICT, words[k][i]);
          nitems++;
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        send(wcm_pkg::MODE_DICT, 8'($urandom));
        nitems++;
      end
      if (ph == 8) begin
        rx_quiet = 1'b0;
        hold_rx = 1'b1;
        fork
          begin repeat (400) @(posedge clk); hold_rx = 1'b0; end
        join_none
      end
      for (int t = 0; t < 120; t++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) send(wcm_pkg::MODE_NEW, 8'($urandom));
        else if (pick < 4) send(wcm_pkg::MODE_CLR, 8'($urandom));
        else if (pick < 12) send(wcm_pkg::MODE_TEXT, 8'($urandom));
        else begin
          pick = $urandom_range(0, nloaded - 1);
          for (int i = 0; i < wl; i++) send(wcm_pkg::MODE_TEXT, words[pick][i]);
          t += wl - 1;
          nitems += wl - 1;
        end
        nitems++;
      end
      rx_quiet = (ph % 5 == 4);
    end
    pause_tx();
    rx_quiet = 1'b0;
    wait_idle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
